// File: sv/sha512_block_hasher_defines.svh
// Assertion macros for the SHA-512 block hasher.
// Used by the top level only; no other dependencies.
`ifndef SHA512_BLOCK_HASHER_DEFINES_SVH
`define SHA512_BLOCK_HASHER_DEFINES_SVH
`ifndef ASSERT_OFF
`define SHA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SHA_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define SHA_ASSERT(label, clk, rst, prop, msg)
`define SHA_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// File: sv/sha512_pkg.sv
// Package for the SHA-512 block hasher: payload types, controller
// states, command struct, round constants and round functions.
`default_nettype none
package sha512_pkg;

  typedef struct packed {
    logic [63:0] message_word;
    logic        first_of_message;
    logic        final_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       load_word;
    logic       reload_iv;
    logic       start_block;
    logic       do_round;
    logic [6:0] round;
    logic       update_cv;
    logic [2:0] emit_index;
  } cmd_t;

  localparam int unsigned ROUNDS = 80;
  localparam int unsigned BLOCK_WORDS = 16;

  localparam logic [63:0] ROUND_K [ROUNDS] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [63:0] INIT_HASH [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] big_sigma0(input logic [63:0] x);
    big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [63:0] big_sigma1(input logic [63:0] x);
    big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [63:0] small_sigma0(input logic [63:0] x);
    small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] small_sigma1(input logic [63:0] x);
    small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage
`default_nettype wire

// File: sv/sha512_ctrl.sv
// Controller for the SHA-512 block hasher: sequences word collection,
// 80 rounds, chaining update and digest emission. Uses sha512_pkg.
`default_nettype none
module sha512_ctrl import sha512_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic in_first,
  input  wire logic in_final,
  output logic      out_valid,
  input  wire logic out_stall,
  output cmd_t      cmd
);

  state_t     state, state_next;
  logic [3:0] word_count, word_count_next;
  logic [6:0] round_count, round_count_next;
  logic [2:0] emit_count, emit_count_next;
  logic       final_seen, final_seen_next;
  logic       in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_COLLECT;
      word_count  <= '0;
      round_count <= '0;
      emit_count  <= '0;
      final_seen  <= 1'b0;
    end else begin
      state       <= state_next;
      word_count  <= word_count_next;
      round_count <= round_count_next;
      emit_count  <= emit_count_next;
      final_seen  <= final_seen_next;
    end
  end

  always_comb begin
    state_next       = state;
    word_count_next  = word_count;
    round_count_next = round_count;
    emit_count_next  = emit_count;
    final_seen_next  = final_seen;
    in_stall         = 1'b1;
    out_valid        = 1'b0;
    in_take          = 1'b0;
    cmd              = '0;
    cmd.round        = round_count;
    cmd.emit_index   = emit_count;
    case (state)
      ST_COLLECT: begin
        in_stall = 1'b0;
        in_take  = in_valid;
        if (in_take) begin
          cmd.load_word = 1'b1;
          cmd.reload_iv = in_first;
          // a first flag restarts the block at word zero
          if (in_first) begin
            word_count_next = 4'd1;
          end else begin
            word_count_next = word_count + 4'd1;
          end
          if ((in_first ? 4'd0 : word_count) == 4'(BLOCK_WORDS - 1)) begin
            final_seen_next  = in_final;
            round_count_next = '0;
            state_next       = ST_ROUND;
            cmd.start_block  = 1'b1;
          end
        end
      end
      ST_ROUND: begin
        cmd.do_round     = 1'b1;
        round_count_next = round_count + 7'd1;
        if (round_count == 7'(ROUNDS - 1)) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update_cv    = 1'b1;
        round_count_next = '0;
        emit_count_next  = '0;
        state_next       = final_seen ? ST_EMIT : ST_COLLECT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          emit_count_next = emit_count + 3'd1;
          if (emit_count == 3'd7) begin
            state_next = ST_COLLECT;
          end
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/sha512_dp.sv
// Datapath for the SHA-512 block hasher: schedule window, working
// variables, chaining value and one round unit. Uses sha512_pkg.
`default_nettype none
module sha512_dp import sha512_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  cmd_t       cmd,
  input  wire logic [63:0] word,
  output logic [63:0] cv_word
);

  logic [63:0] sched [BLOCK_WORDS];
  logic [63:0] v [8];
  logic [63:0] cv [8];
  logic [63:0] wt, w_new, t1, t2;
  logic [63:0] ch, maj;

  // the window shifts: sched[0] is always the oldest word
  always_comb begin
    w_new = sched[0] + small_sigma0(sched[1]) + sched[9] + small_sigma1(sched[14]);
    wt    = (cmd.round < 7'(BLOCK_WORDS)) ? sched[0] : w_new;
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1    = v[7] + big_sigma1(v[4]) + ch + ROUND_K[cmd.round] + wt;
    t2    = big_sigma0(v[0]) + maj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        cv[i] <= INIT_HASH[i];
        v[i]  <= '0;
      end
    end else begin
      if (cmd.load_word) begin
        if (cmd.reload_iv) begin
          for (int i = 0; i < 8; i++) cv[i] <= INIT_HASH[i];
        end
        for (int i = 0; i < BLOCK_WORDS - 1; i++) sched[i] <= sched[i + 1];
        sched[BLOCK_WORDS - 1] <= word;
      end
      if (cmd.start_block) begin
        for (int i = 0; i < 8; i++) begin
          v[i] <= cmd.reload_iv ? INIT_HASH[i] : cv[i];
        end
      end
      if (cmd.do_round) begin
        v[7] <= v[6];
        v[6] <= v[5];
        v[5] <= v[4];
        v[4] <= v[3] + t1;
        v[3] <= v[2];
        v[2] <= v[1];
        v[1] <= v[0];
        v[0] <= t1 + t2;
        for (int i = 0; i < BLOCK_WORDS - 1; i++) sched[i] <= sched[i + 1];
        sched[BLOCK_WORDS - 1] <= wt;
      end
      if (cmd.update_cv) begin
        for (int i = 0; i < 8; i++) cv[i] <= cv[i] + v[i];
      end
    end
  end

  assign cv_word = cv[cmd.emit_index];

endmodule
`default_nettype wire

// File: sv/sha512_block_hasher.sv
// SHA-512 block hasher top level: 16 words per block, then 80 rounds at one
// per cycle and a chaining update; the input stays stalled after the 16th word
// through the rounds and the update. Final blocks then show 8 digest words,
// one per cycle without stall. Synchronous reset loads the initial hash,
// clears counters and working variables.
`default_nettype none
`include "sha512_block_hasher_defines.svh"
module sha512_block_hasher import sha512_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);

  cmd_t        cmd;
  logic [63:0] cv_word;

  sha512_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_first  (in_data.first_of_message),
    .in_final  (in_data.final_block),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  sha512_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .word    (in_data.message_word),
    .cv_word (cv_word)
  );

  always_comb begin
    out_data.digest_word  = cv_word;
    out_data.digest_index = cmd.emit_index;
    out_data.digest_last  = (cmd.emit_index == 3'd7);
  end

  `SHA_ASSERT(a_no_overlap, clk, rst, !(out_valid && !in_stall), "input open while emitting")
  `SHA_ASSERT(a_round_quiet, clk, rst, !(cmd.do_round && !in_stall), "input open during rounds")
  `SHA_ASSERT_NEXT(a_emit_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data.digest_index), "digest index moved under stall")

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for sha512_block_hasher: a random-gap driver feeds random
// message words, a monitor compares digest words against an in-bench SHA-512 model.
// Depends on sha512_pkg for the payload types and the round and initial constants.
`default_nettype none
module tb_top;
  import sha512_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  sha512_block_hasher uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hasher state mirror
  logic [63:0] chain_h [8];
  logic [63:0] block_w [16];
  logic [3:0]  words_held;
  out_item_t   digest_q [$];
  in_item_t    word_q [$];
  int unsigned fail_count = 0;
  bit          hold_for_drain = 1'b0;
  bit          in_took = 1'b0;

  function automatic logic [63:0] ror64(logic [63:0] x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress_words();
    logic [63:0] w [16];
    logic [63:0] v [8];
    logic [63:0] wt, t1, t2, x15, x2;
    for (int j = 0; j < 16; j++) w[j] = block_w[j];
    for (int j = 0; j < 8; j++) v[j] = chain_h[j];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wt = w[r];
      end else begin
        x15 = w[(r + 1) % 16];
        x2 = w[(r + 14) % 16];
        wt = w[r % 16] + (ror64(x15, 1) ^ ror64(x15, 8) ^ (x15 >> 7)) + w[(r + 9) % 16]
             + (ror64(x2, 19) ^ ror64(x2, 61) ^ (x2 >> 6));
        w[r % 16] = wt;
      end
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wt;
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) chain_h[j] = chain_h[j] + v[j];
    for (int j = 0; j < 16; j++) block_w[j] = w[j];
  endtask

  task automatic hash_word(in_item_t it);
    out_item_t d;
    if (it.first_of_message) begin
      for (int j = 0; j < 8; j++) chain_h[j] = INIT_HASH[j];
      words_held = '0;
    end
    block_w[words_held] = it.message_word;
    words_held = words_held + 4'd1;
    if (words_held == 4'd0) begin
      compress_words();
      if (it.final_block) begin
        for (int k = 0; k < 8; k++) begin
          d.digest_word = chain_h[k];
          d.digest_index = 3'(k);
          d.digest_last = (k == 7);
          digest_q.push_back(d);
        end
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  task automatic add_word(logic [63:0] w, bit first, bit fin);
    in_item_t it;
    it.message_word = w;
    it.first_of_message = first;
    it.final_block = fin;
    word_q.push_back(it);
  endtask

  // One block of 16 words; first on word 0, final on word 15, final noise on others.
  task automatic add_block(bit first, bit fin);
    for (int i = 0; i < 16; i++)
      add_word(pick_word(), first && i == 0, (i == 15) ? fin : bit'($urandom_range(0, 1)));
  endtask

  // Record whether the item on the input was taken at this edge.
  always @(posedge clk) begin
    in_took <= !rst && in_valid && !in_stall;
  end

  // Driver: change at falling edge, hold while stalled.
  int unsigned gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_took) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (word_q.size() > 0 && !hold_for_drain) begin
          in_data <= word_q.pop_front();
          in_valid <= 1'b1;
          gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern
  int unsigned stall_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_valid) stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
      end
    end
  end

  // Monitor: model on input acceptance, compare on output acceptance.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (in_valid && !in_stall) hash_word(in_data);
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected digest word", out_data.digest_word, '0);
        end else begin
          want = digest_q.pop_front();
          if (out_data.digest_word !== want.digest_word)
            report_mismatch("digest_word", out_data.digest_word, want.digest_word);
          if (out_data.digest_index !== want.digest_index)
            report_mismatch("digest_index", 64'(out_data.digest_index), 64'(want.digest_index));
          if (out_data.digest_last !== want.digest_last)
            report_mismatch("digest_last", 64'(out_data.digest_last), 64'(want.digest_last));
        end
      end
    end
  end

  initial begin
    for (int j = 0; j < 8; j++) chain_h[j] = INIT_HASH[j];
    for (int j = 0; j < 16; j++) block_w[j] = '0;
    words_held = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: a message with all-zero words, then all-ones chained without reload.
    for (int i = 0; i < 16; i++) add_word('0, i == 0, i == 15);
    for (int i = 0; i < 16; i++) add_word('1, 1'b0, 1'b1);
    // Restart mid-block drops the partial block.
    for (int i = 0; i < 5; i++) add_word(rand64(), i == 0, 1'b1);
    add_block(1'b1, 1'b1);

    // Pause until all digests are out.
    wait (word_q.size() == 0 && !in_valid);
    hold_for_drain = 1'b1;
    wait (digest_q.size() == 0);
    repeat (100) @(posedge clk);
    hold_for_drain = 1'b0;

    // Random messages: mostly well-formed, one to three blocks, some broken prefixes.
    while (word_q.size() < 280 - 69) begin
      if ($urandom_range(0, 5) == 0) begin
        for (int i = $urandom_range(1, 15); i > 0; i--)
          add_word(pick_word(), i == 1 ? 1'b0 : bit'($urandom_range(0, 1)), 1'b0);
      end else begin
        int unsigned nb;
        nb = $urandom_range(1, 3);
        for (int b = 0; b < nb; b++)
          add_block(b == 0 ? bit'($urandom_range(0, 7) != 0) : 1'b0, b == nb - 1);
      end
    end
    // Make sure the tail ends on a complete final block.
    add_block(1'b1, 1'b1);

    wait (word_q.size() == 0 && !in_valid);
    wait (digest_q.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
